### sv/swr_pkg.sv
package swr_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam int SAMPLE_W  = 32;
    localparam int MIN_DUTY_W = 20;
    localparam logic [MIN_DUTY_W-1:0] MIN_DUTY_RESET = 20'd500;
    localparam logic [16:0] DUTY_ONE = 17'h10000;

    localparam logic [2:0] ST_VALID          = 3'd0;
    localparam logic [2:0] ST_OUT_OF_RANGE   = 3'd1;
    localparam logic [2:0] ST_INVALID        = 3'd2;
    localparam logic [2:0] ST_STALE          = 3'd3;
    localparam logic [2:0] ST_WAITING        = 3'd4;
    localparam logic [2:0] ST_NOT_CONFIGURED = 3'd5;

    typedef struct packed {
        logic [2:0]         sample_state;
        logic               sensor_configured;
        logic signed [15:0] input_voltage_mv;
        logic signed [15:0] input_current_mv;
        logic signed [23:0] voltage_mv;
        logic signed [23:0] current_ma;
        logic signed [31:0] power_mw;
        logic               close_window;
        logic [31:0]        now_ms;
    } sample_t;

    typedef struct packed {
        logic       seen_configured;
        logic       seen_rejection;
        logic [2:0] rejection_code;
    } flags_t;

endpackage

### sv/swr_accum.sv
module swr_accum
    import swr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      acc_en,
    input  logic                      clear,
    input  sample_t                   sample,
    output logic [COUNT_WIDTH-1:0]    observed_count,
    output logic [COUNT_WIDTH-1:0]    valid_count,
    output logic [COUNT_WIDTH+15:0]   input_voltage_total,
    output logic [COUNT_WIDTH+15:0]   input_current_total,
    output logic [COUNT_WIDTH+23:0]   voltage_total,
    output logic [COUNT_WIDTH+23:0]   current_total,
    output logic [COUNT_WIDTH+31:0]   power_total,
    output logic [COUNT_WIDTH+31:0]   magnitude_total,
    output logic [SAMPLE_W-1:0]       largest_magnitude,
    output logic [SAMPLE_W-1:0]       second_magnitude,
    output flags_t                    flags
);

    localparam int CW   = COUNT_WIDTH;
    localparam int IV_W = CW + 16;
    localparam int V_W  = CW + 24;
    localparam int P_W  = CW + 32;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
    localparam flags_t FLAGS_CLEAR = '{seen_configured: 1'b0, seen_rejection: 1'b0,
                                       rejection_code: ST_INVALID};

    logic [CW-1:0]       obs_reg, obs_next;
    logic [CW-1:0]       val_reg, val_next;
    logic [IV_W-1:0]     ivt_reg, ivt_next;
    logic [IV_W-1:0]     ict_reg, ict_next;
    logic [V_W-1:0]      vt_reg, vt_next;
    logic [V_W-1:0]      ct_reg, ct_next;
    logic [P_W-1:0]      pt_reg, pt_next;
    logic [P_W-1:0]      mt_reg, mt_next;
    logic [SAMPLE_W-1:0] lg_reg, lg_next;
    logic [SAMPLE_W-1:0] sc_reg, sc_next;
    flags_t              flags_reg, flags_next;

    logic [2:0]          st;
    logic                is_valid;
    logic                is_obs;
    logic [31:0]         p_u;
    logic [31:0]         mag;

    always_comb
    begin
        st       = (sample.sample_state > ST_NOT_CONFIGURED) ? ST_INVALID : sample.sample_state;
        is_valid = (st == ST_VALID);
        is_obs   = is_valid || (st == ST_OUT_OF_RANGE);
        p_u      = sample.power_mw;
        mag      = p_u[31] ? (~p_u + 32'd1) : p_u;

        obs_next   = obs_reg;
        val_next   = val_reg;
        ivt_next   = ivt_reg;
        ict_next   = ict_reg;
        vt_next    = vt_reg;
        ct_next    = ct_reg;
        pt_next    = pt_reg;
        mt_next    = mt_reg;
        lg_next    = lg_reg;
        sc_next    = sc_reg;
        flags_next = flags_reg;

        if (acc_en)
        begin
            if (sample.sensor_configured)
            begin
                flags_next.seen_configured = 1'b1;
            end
            if (is_obs && (obs_reg != CNT_MAX))
            begin
                obs_next = obs_reg + 1'b1;
                ivt_next = ivt_reg + {{CW{sample.input_voltage_mv[15]}}, sample.input_voltage_mv};
                ict_next = ict_reg + {{CW{sample.input_current_mv[15]}}, sample.input_current_mv};
                vt_next  = vt_reg + {{CW{sample.voltage_mv[23]}}, sample.voltage_mv};
                ct_next  = ct_reg + {{CW{sample.current_ma[23]}}, sample.current_ma};
                pt_next  = pt_reg + {{CW{sample.power_mw[31]}}, sample.power_mw};
            end
            if (is_valid)
            begin
                if (val_reg != CNT_MAX)
                begin
                    val_next = val_reg + 1'b1;
                    mt_next  = mt_reg + {{CW{1'b0}}, mag};
                end
                if (mag >= lg_reg)
                begin
                    sc_next = lg_reg;
                    lg_next = mag;
                end
                else if (mag > sc_reg)
                begin
                    sc_next = mag;
                end
            end
            else
            begin
                flags_next.seen_rejection = 1'b1;
                if (st == ST_OUT_OF_RANGE)
                begin
                    flags_next.rejection_code = ST_OUT_OF_RANGE;
                end
                else if (flags_reg.rejection_code != ST_OUT_OF_RANGE)
                begin
                    flags_next.rejection_code = st;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obs_reg   <= '0;
            val_reg   <= '0;
            ivt_reg   <= '0;
            ict_reg   <= '0;
            vt_reg    <= '0;
            ct_reg    <= '0;
            pt_reg    <= '0;
            mt_reg    <= '0;
            lg_reg    <= '0;
            sc_reg    <= '0;
            flags_reg <= FLAGS_CLEAR;
        end
        else if (clear)
        begin
            obs_reg   <= '0;
            val_reg   <= '0;
            ivt_reg   <= '0;
            ict_reg   <= '0;
            vt_reg    <= '0;
            ct_reg    <= '0;
            pt_reg    <= '0;
            mt_reg    <= '0;
            lg_reg    <= '0;
            sc_reg    <= '0;
            flags_reg <= FLAGS_CLEAR;
        end
        else
        begin
            obs_reg   <= obs_next;
            val_reg   <= val_next;
            ivt_reg   <= ivt_next;
            ict_reg   <= ict_next;
            vt_reg    <= vt_next;
            ct_reg    <= ct_next;
            pt_reg    <= pt_next;
            mt_reg    <= mt_next;
            lg_reg    <= lg_next;
            sc_reg    <= sc_next;
            flags_reg <= flags_next;
        end
    end

    assign observed_count      = obs_reg;
    assign valid_count         = val_reg;
    assign input_voltage_total = ivt_reg;
    assign input_current_total = ict_reg;
    assign voltage_total       = vt_reg;
    assign current_total       = ct_reg;
    assign power_total         = pt_reg;
    assign magnitude_total     = mt_reg;
    assign largest_magnitude   = lg_reg;
    assign second_magnitude    = sc_reg;
    assign flags               = flags_reg;

endmodule

### sv/swr_divider.sv
module swr_divider
    import swr_pkg::*;
#(
    parameter int DIVIDEND_W = 48,
    parameter int DIVISOR_W  = SAMPLE_W
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] q_reg, q_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    always_comb
    begin
        shifted  = {rem_reg, q_reg[DIVIDEND_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        cnt_next = cnt_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIVIDEND_W);
            q_next   = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            q_next   = {q_reg[DIVIDEND_W-2:0], ge};
            rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = q_reg;

endmodule

### sv/sample_window_reducer_top.sv
// Channel   Direction  Transaction
// s_axis    in         one classified sample (tlast closes the window)
// m_axis    out        one window result per closing sample
// apb       in/out     min_duty_power_mw at byte address 0
//
// A sample that does not close the window is captured, then accumulated.
// A closing sample adds 7 divisions, each a load then a run, on the shared
// one-bit-per-cycle restoring divider, DIV_W = max(32 + COUNT_WIDTH, 48).
// Reset clears all window state at once; no clearing pass follows.
// The result waits in the output register; a new result waits until it is taken.
module sample_window_reducer_top
    import swr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // input_voltage_mv, input_current_mv, voltage_mv, current_ma, power_mw, now_ms
    input  logic [143:0] s_axis_tdata,
    // sample_state, sensor_configured
    input  logic [3:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // mean_input_voltage_mv, mean_input_current_mv, mean_voltage_mv, mean_current_ma,
    // mean_power_mw, duty_fraction, stamp_ms, zero fill
    output logic [167:0] m_axis_tdata,
    // window_state, window_configured, duty_reported
    output logic [4:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int CW    = COUNT_WIDTH;
    localparam int IV_W  = CW + 16;
    localparam int V_W   = CW + 24;
    localparam int P_W   = CW + 32;
    localparam int DIV_W = (CW + 32 > 48) ? (CW + 32) : 48;

    localparam logic [2:0] JOB_IN_V  = 3'd0;
    localparam logic [2:0] JOB_IN_C  = 3'd1;
    localparam logic [2:0] JOB_V     = 3'd2;
    localparam logic [2:0] JOB_C     = 3'd3;
    localparam logic [2:0] JOB_P     = 3'd4;
    localparam logic [2:0] JOB_MAG   = 3'd5;
    localparam logic [2:0] JOB_DUTY  = 3'd6;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ACC  = 5'b00010,
        S_LOAD = 5'b00100,
        S_RUN  = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           job_reg, job_next;
    sample_t              sample_reg;
    logic [MIN_DUTY_W-1:0] min_reg;

    logic [15:0]          miv_reg;
    logic [15:0]          mic_reg;
    logic [23:0]          mv_reg;
    logic [23:0]          mc_reg;
    logic [31:0]          mp_reg;
    logic [31:0]          mmag_reg;
    logic [16:0]          dq_reg;

    logic                 out_valid_reg;
    logic [167:0]         out_data_reg;
    logic [4:0]           out_user_reg;

    logic [CW-1:0]        obs_cnt;
    logic [CW-1:0]        val_cnt;
    logic [IV_W-1:0]      ivt;
    logic [IV_W-1:0]      ict;
    logic [V_W-1:0]       vt;
    logic [V_W-1:0]       ct;
    logic [P_W-1:0]       pt;
    logic [P_W-1:0]       mt;
    logic [SAMPLE_W-1:0]  largest;
    logic [SAMPLE_W-1:0]  second;
    flags_t               flags;

    logic                 s_accept;
    logic                 acc_en;
    logic                 acc_clear;
    logic                 div_start;
    logic                 div_busy;
    logic [DIV_W-1:0]     quotient;
    logic [DIV_W-1:0]     sel_total;
    logic                 sel_signed;
    logic                 neg_sel;
    logic [DIV_W-1:0]     dividend;
    logic [SAMPLE_W-1:0]  divisor;
    logic [DIV_W-1:0]     q_signed;
    logic [SAMPLE_W-1:0]  peak;
    logic                 out_free;

    logic [2:0]           wstate;
    logic                 means_ok;
    logic                 duty_rep;
    logic                 duty_low;
    logic [16:0]          duty_val;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign pready        = 1'b1;
    assign prdata        = paddr[2] ? 32'd0 : {{(32 - MIN_DUTY_W){1'b0}}, min_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_DUTY_RESET;
        end
        else if (psel && penable && pwrite && pready && !paddr[2])
        begin
            min_reg <= pwdata[MIN_DUTY_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            sample_reg.sample_state      <= s_axis_tuser[2:0];
            sample_reg.sensor_configured <= s_axis_tuser[3];
            sample_reg.input_voltage_mv  <= s_axis_tdata[15:0];
            sample_reg.input_current_mv  <= s_axis_tdata[31:16];
            sample_reg.voltage_mv        <= s_axis_tdata[55:32];
            sample_reg.current_ma        <= s_axis_tdata[79:56];
            sample_reg.power_mw          <= s_axis_tdata[111:80];
            sample_reg.close_window      <= s_axis_tlast;
            sample_reg.now_ms            <= s_axis_tdata[143:112];
        end
    end

    swr_accum #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_accum (
        .clk                 (clk),
        .rst_n               (rst_n),
        .acc_en              (acc_en),
        .clear               (acc_clear),
        .sample              (sample_reg),
        .observed_count      (obs_cnt),
        .valid_count         (val_cnt),
        .input_voltage_total (ivt),
        .input_current_total (ict),
        .voltage_total       (vt),
        .current_total       (ct),
        .power_total         (pt),
        .magnitude_total     (mt),
        .largest_magnitude   (largest),
        .second_magnitude    (second),
        .flags               (flags)
    );

    assign peak = (val_cnt > CW'(1)) ? second : largest;

    always_comb
    begin
        sel_signed = 1'b1;
        unique case (job_reg)
            JOB_IN_V:
            begin
                sel_total = {{(DIV_W - IV_W){ivt[IV_W-1]}}, ivt};
                divisor   = {{(SAMPLE_W - CW){1'b0}}, obs_cnt};
            end
            JOB_IN_C:
            begin
                sel_total = {{(DIV_W - IV_W){ict[IV_W-1]}}, ict};
                divisor   = {{(SAMPLE_W - CW){1'b0}}, obs_cnt};
            end
            JOB_V:
            begin
                sel_total = {{(DIV_W - V_W){vt[V_W-1]}}, vt};
                divisor   = {{(SAMPLE_W - CW){1'b0}}, obs_cnt};
            end
            JOB_C:
            begin
                sel_total = {{(DIV_W - V_W){ct[V_W-1]}}, ct};
                divisor   = {{(SAMPLE_W - CW){1'b0}}, obs_cnt};
            end
            JOB_P:
            begin
                sel_total = DIV_W'({{(DIV_W - P_W + 1){pt[P_W-1]}}, pt});
                divisor   = {{(SAMPLE_W - CW){1'b0}}, obs_cnt};
            end
            JOB_MAG:
            begin
                sel_total  = DIV_W'({1'b0, mt});
                divisor    = {{(SAMPLE_W - CW){1'b0}}, val_cnt};
                sel_signed = 1'b0;
            end
            JOB_DUTY:
            begin
                sel_total  = DIV_W'({mmag_reg, 16'd0});
                divisor    = peak;
                sel_signed = 1'b0;
            end
            default:
            begin
                sel_total  = '0;
                divisor    = '0;
                sel_signed = 1'b0;
            end
        endcase
        neg_sel  = sel_signed && sel_total[DIV_W-1];
        dividend = neg_sel ? (~sel_total + 1'b1) : sel_total;
        q_signed = neg_sel ? (~quotient + 1'b1) : quotient;
    end

    swr_divider #(
        .DIVIDEND_W(DIV_W),
        .DIVISOR_W (SAMPLE_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_RUN) && !div_busy)
        begin
            unique case (job_reg)
                JOB_IN_V: miv_reg  <= q_signed[15:0];
                JOB_IN_C: mic_reg  <= q_signed[15:0];
                JOB_V:    mv_reg   <= q_signed[23:0];
                JOB_C:    mc_reg   <= q_signed[23:0];
                JOB_P:    mp_reg   <= q_signed[31:0];
                JOB_MAG:  mmag_reg <= quotient[31:0];
                JOB_DUTY: dq_reg   <= (quotient > DIV_W'(DUTY_ONE)) ? DUTY_ONE
                                                                    : quotient[16:0];
                default:  mmag_reg <= mmag_reg;
            endcase
        end
    end

    always_comb
    begin
        means_ok = flags.seen_configured && (obs_cnt != '0);
        priority if (!flags.seen_configured)
        begin
            wstate = ST_NOT_CONFIGURED;
        end
        else if (obs_cnt == '0)
        begin
            wstate = flags.seen_rejection ? flags.rejection_code : ST_WAITING;
        end
        else
        begin
            wstate = flags.seen_rejection ? flags.rejection_code : ST_VALID;
        end
        duty_rep = means_ok && (wstate == ST_VALID) && (val_cnt != '0);
        duty_low = (mmag_reg < 32'(min_reg)) || (peak < 32'(min_reg)) || (peak == '0);
        duty_val = !duty_rep ? 17'd0 : (duty_low ? DUTY_ONE : dq_reg);
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        acc_en     = 1'b0;
        acc_clear  = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                acc_en   = 1'b1;
                job_next = JOB_IN_V;
                state_next = sample_reg.close_window ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                div_start  = 1'b1;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (!div_busy)
                begin
                    if (job_reg == JOB_DUTY)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        job_next   = job_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    acc_clear  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= JOB_IN_V;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            if ((state_reg == S_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_EMIT) && out_free)
        begin
            out_data_reg <= {7'd0,
                             sample_reg.now_ms,
                             duty_val,
                             means_ok ? mp_reg  : 32'd0,
                             means_ok ? mc_reg  : 24'd0,
                             means_ok ? mv_reg  : 24'd0,
                             means_ok ? mic_reg : 16'd0,
                             means_ok ? miv_reg : 16'd0};
            out_user_reg <= {duty_rep, flags.seen_configured, wstate};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    a_acc_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("accumulate step without an accepted sample");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside the emit step");

    a_duty_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[4]) |->
        (m_axis_tuser[2:0] == ST_VALID && m_axis_tuser[3]))
        else $error("duty reported for a window that is not valid");

    a_divider_started: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |=> div_busy)
        else $error("divider did not start");

    a_idle_divider: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !div_busy)
        else $error("sample accepted while a division runs");

endmodule
